// ===== hw/rtl/vcpu_load_balancer_defines.svh =====
// Assertion helpers for the load balancer.
`ifndef VCPU_LOAD_BALANCER_DEFINES_SVH
`define VCPU_LOAD_BALANCER_DEFINES_SVH

`ifndef SYNTHESIS
`define VLB_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vlb assertion failed");
`define VLB_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("vlb forbidden condition");
`else
`define VLB_ASSERT(label, prop)
`define VLB_ASSERT_NEVER(label, expr)
`endif

`endif

// ===== hw/rtl/vlb_pkg.sv =====
package vlb_pkg;

    localparam int NUM_CPUS  = 8;
    localparam int MAX_VCPUS = 32;

    localparam int CPU_W   = $clog2(NUM_CPUS);
    localparam int N_W     = $clog2(NUM_CPUS + 1);
    localparam int ACT_W   = 4;
    localparam int MARGIN_W = 8;
    localparam int REC_AW  = $clog2(MAX_VCPUS);
    localparam int COUNT_W = $clog2(MAX_VCPUS + 1);
    localparam int LOAD_W  = 32;
    localparam int USE_W   = 24;
    localparam int VM_W    = 4;
    localparam int VCPU_W  = 3;
    localparam int TOT_W   = LOAD_W + CPU_W;
    localparam int MUL_B_W = MARGIN_W + 1;
    localparam int PROD_W  = TOT_W + MUL_B_W;
    localparam int CMP_W   = PROD_W + MARGIN_W;

    localparam logic [1:0] CFG_ACTIVE_CPUS = 2'd0;
    localparam logic [1:0] CFG_HIGH_MARGIN = 2'd1;
    localparam logic [1:0] CFG_VARIANCE    = 2'd2;

    typedef struct packed {
        logic [VM_W-1:0]   vm;
        logic [VCPU_W-1:0] vcpu;
        logic [CPU_W-1:0]  cpu;
        logic [USE_W-1:0]  usage;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

endpackage

// ===== hw/rtl/vcpu_load_balancer.sv =====
// While idle, record loading takes one request per cycle, with no result for
// non-final records; no stall input. A final request starts a balancing pass:
// setup sums the loads and forms the limits, then each record is checked through
// one shared multiplier before the done result is issued. Each move and the done
// result are strobed for one cycle. Configuration writes are taken only while idle.
// rst_n is asynchronous active low: loads and record count clear, registers reset.
`include "vcpu_load_balancer_defines.svh"

module vcpu_load_balancer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [vlb_pkg::VM_W-1:0]    vm_index,
    input  logic [vlb_pkg::VCPU_W-1:0]  vcpu_index,
    input  logic [vlb_pkg::CPU_W-1:0]   current_cpu,
    input  logic [vlb_pkg::USE_W-1:0]   usage_delta,
    input  logic                        final_item,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [7:0]                  cfg_data,
    output logic                        result_valid,
    output logic                        kind,
    output logic [vlb_pkg::VM_W-1:0]    out_vm,
    output logic [vlb_pkg::VCPU_W-1:0]  out_vcpu,
    output logic [vlb_pkg::CPU_W-1:0]   from_cpu,
    output logic [vlb_pkg::CPU_W-1:0]   to_cpu,
    output logic                        end_of_run
);
    import vlb_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SUM     = 4'd1;
    localparam logic [3:0] S_LIM_HI  = 4'd2;
    localparam logic [3:0] S_LIM_LO  = 4'd3;
    localparam logic [3:0] S_LIM_DST = 4'd4;
    localparam logic [3:0] S_LIM_END = 4'd5;
    localparam logic [3:0] S_RD      = 4'd6;
    localparam logic [3:0] S_REC     = 4'd7;
    localparam logic [3:0] S_SRC     = 4'd8;
    localparam logic [3:0] S_CHK1    = 4'd9;
    localparam logic [3:0] S_CHK2    = 4'd10;
    localparam logic [3:0] S_MIN     = 4'd11;
    localparam logic [3:0] S_DST     = 4'd12;
    localparam logic [3:0] S_CHK3    = 4'd13;
    localparam logic [3:0] S_DONE    = 4'd14;

    logic [3:0]          state_reg, state_next;
    logic [ACT_W-1:0]    active_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [MARGIN_W-1:0] variance_reg;
    logic [LOAD_W-1:0]   load_reg [NUM_CPUS];
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  idx_reg;
    logic [N_W-1:0]      scan_reg;
    logic [TOT_W-1:0]    tot_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   hi_reg, lo_reg, dst_reg;
    rec_t                rec_reg;
    logic [LOAD_W-1:0]   src_load_reg, rest_reg, best_load_reg;
    logic [CPU_W-1:0]    best_reg;

    logic                result_valid_reg, kind_reg;
    logic [VM_W-1:0]     out_vm_reg;
    logic [VCPU_W-1:0]   out_vcpu_reg;
    logic [CPU_W-1:0]    from_cpu_reg, to_cpu_reg;

    logic [N_W-1:0]      n_cur;
    logic                accept;
    logic                store_ok;
    logic [CPU_W-1:0]    rd_cpu;
    logic [LOAD_W-1:0]   rd_load;
    logic [TOT_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   prod_next;
    logic [CMP_W-1:0]    prod_scaled;
    logic [LOAD_W-1:0]   rest_cur;
    logic [COUNT_W-1:0]  idx_inc;
    logic [3:0]          after_rec;
    rec_t                ram_wdata, ram_rdata;
    logic [MUL_B_W-1:0]  n_ext;

    always_comb
    begin
        if (active_reg == '0)
        begin
            n_cur = N_W'(1);
        end
        else if (N_W'(active_reg) > N_W'(NUM_CPUS))
        begin
            n_cur = N_W'(NUM_CPUS);
        end
        else
        begin
            n_cur = N_W'(active_reg);
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy && !start;
    assign accept    = start && !busy;
    assign store_ok  = (N_W'(current_cpu) < n_cur) && (count_reg < COUNT_W'(MAX_VCPUS));
    assign n_ext     = MUL_B_W'(n_cur);
    assign idx_inc   = idx_reg + COUNT_W'(1);
    assign after_rec = (idx_inc == count_reg) ? S_DONE : S_RD;
    assign prod_scaled = {prod_reg, {MARGIN_W{1'b0}}};
    assign rest_cur  = (src_load_reg >= LOAD_W'(rec_reg.usage)) ?
                       src_load_reg - LOAD_W'(rec_reg.usage) : '0;

    assign ram_wdata.vm    = vm_index;
    assign ram_wdata.vcpu  = vcpu_index;
    assign ram_wdata.cpu   = current_cpu;
    assign ram_wdata.usage = usage_delta;

    vlb_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_VCPUS)
    ) u_records (
        .clk   (clk),
        .we    (accept && store_ok),
        .waddr (count_reg[REC_AW-1:0]),
        .wdata (ram_wdata),
        .raddr (idx_reg[REC_AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  rd_cpu = current_cpu;
            S_SUM:   rd_cpu = scan_reg[CPU_W-1:0];
            S_SRC:   rd_cpu = rec_reg.cpu;
            S_MIN:   rd_cpu = scan_reg[CPU_W-1:0];
            default: rd_cpu = '0;
        endcase
    end

    assign rd_load = load_reg[rd_cpu];

    always_comb
    begin
        mul_a = tot_reg;
        mul_b = n_ext;
        unique case (state_reg)
            S_LIM_HI:  mul_b = MUL_B_W'(256) + MUL_B_W'(margin_reg);
            S_LIM_LO:  mul_b = MUL_B_W'(256) - MUL_B_W'(variance_reg);
            S_LIM_DST: mul_b = MUL_B_W'(256) + MUL_B_W'(variance_reg);
            S_SRC:     mul_a = TOT_W'(rd_load);
            S_CHK1:    mul_a = TOT_W'(rest_cur);
            S_DST:     mul_a = TOT_W'(best_load_reg) + TOT_W'(rec_reg.usage);
            default:   mul_a = tot_reg;
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    state_next = (accept && final_item) ? S_SUM : S_IDLE;
            S_SUM:     state_next = (scan_reg == n_cur - N_W'(1)) ? S_LIM_HI : S_SUM;
            S_LIM_HI:  state_next = S_LIM_LO;
            S_LIM_LO:  state_next = S_LIM_DST;
            S_LIM_DST: state_next = S_LIM_END;
            S_LIM_END: state_next = (tot_reg == '0 || count_reg == '0) ? S_DONE : S_RD;
            S_RD:      state_next = S_REC;
            S_REC:     state_next = (N_W'(ram_rdata.cpu) >= n_cur) ? after_rec : S_SRC;
            S_SRC:     state_next = S_CHK1;
            S_CHK1:    state_next = (prod_scaled < CMP_W'(hi_reg)) ? after_rec : S_CHK2;
            S_CHK2:
            begin
                if (prod_scaled < CMP_W'(lo_reg))
                begin
                    state_next = after_rec;
                end
                else
                begin
                    state_next = (n_cur == N_W'(1)) ? S_DST : S_MIN;
                end
            end
            S_MIN:     state_next = (scan_reg == n_cur - N_W'(1)) ? S_DST : S_MIN;
            S_DST:     state_next = (best_reg == rec_reg.cpu) ? after_rec : S_CHK3;
            S_CHK3:    state_next = after_rec;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            active_reg       <= ACT_W'(8);
            margin_reg       <= MARGIN_W'(64);
            variance_reg     <= MARGIN_W'(102);
            for (int c = 0; c < NUM_CPUS; c++)
            begin
                load_reg[c] <= '0;
            end
            count_reg        <= '0;
            idx_reg          <= '0;
            scan_reg         <= '0;
            tot_reg          <= '0;
            prod_reg         <= '0;
            hi_reg           <= '0;
            lo_reg           <= '0;
            dst_reg          <= '0;
            rec_reg          <= '0;
            src_load_reg     <= '0;
            rest_reg         <= '0;
            best_load_reg    <= '0;
            best_reg         <= '0;
            result_valid_reg <= 1'b0;
            kind_reg         <= 1'b0;
            out_vm_reg       <= '0;
            out_vcpu_reg     <= '0;
            from_cpu_reg     <= '0;
            to_cpu_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            prod_reg         <= prod_next;
            result_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_ACTIVE_CPUS: active_reg   <= cfg_data[ACT_W-1:0];
                    CFG_HIGH_MARGIN: margin_reg   <= cfg_data;
                    CFG_VARIANCE:    variance_reg <= cfg_data;
                    default:         active_reg   <= active_reg;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && store_ok)
                    begin
                        load_reg[current_cpu] <= rd_load + LOAD_W'(usage_delta);
                        count_reg <= count_reg + COUNT_W'(1);
                    end
                    scan_reg <= '0;
                    tot_reg  <= '0;
                    idx_reg  <= '0;
                end
                S_SUM:
                begin
                    tot_reg  <= tot_reg + TOT_W'(rd_load);
                    scan_reg <= scan_reg + N_W'(1);
                end
                S_LIM_LO:  hi_reg <= prod_reg;
                S_LIM_DST: lo_reg <= prod_reg;
                S_LIM_END: dst_reg <= prod_reg;
                S_RD:
                begin
                end
                S_REC:
                begin
                    rec_reg <= ram_rdata;
                    if (N_W'(ram_rdata.cpu) >= n_cur)
                    begin
                        idx_reg <= idx_inc;
                    end
                end
                S_SRC:
                begin
                    src_load_reg <= rd_load;
                end
                S_CHK1:
                begin
                    rest_reg <= rest_cur;
                    if (prod_scaled < CMP_W'(hi_reg))
                    begin
                        idx_reg <= idx_inc;
                    end
                end
                S_CHK2:
                begin
                    best_reg      <= '0;
                    best_load_reg <= load_reg[0];
                    scan_reg      <= N_W'(1);
                    if (prod_scaled < CMP_W'(lo_reg))
                    begin
                        idx_reg <= idx_inc;
                    end
                end
                S_MIN:
                begin
                    if (rd_load < best_load_reg)
                    begin
                        best_reg      <= scan_reg[CPU_W-1:0];
                        best_load_reg <= rd_load;
                    end
                    scan_reg <= scan_reg + N_W'(1);
                end
                S_DST:
                begin
                    if (best_reg == rec_reg.cpu)
                    begin
                        idx_reg <= idx_inc;
                    end
                end
                S_CHK3:
                begin
                    if (prod_scaled <= CMP_W'(dst_reg))
                    begin
                        load_reg[best_reg]    <= best_load_reg + LOAD_W'(rec_reg.usage);
                        load_reg[rec_reg.cpu] <= rest_reg;
                        result_valid_reg      <= 1'b1;
                        kind_reg              <= 1'b0;
                        out_vm_reg            <= rec_reg.vm;
                        out_vcpu_reg          <= rec_reg.vcpu;
                        from_cpu_reg          <= rec_reg.cpu;
                        to_cpu_reg            <= best_reg;
                    end
                    idx_reg <= idx_inc;
                end
                S_DONE:
                begin
                    result_valid_reg <= 1'b1;
                    kind_reg         <= 1'b1;
                    out_vm_reg       <= '0;
                    out_vcpu_reg     <= '0;
                    from_cpu_reg     <= '0;
                    to_cpu_reg       <= '0;
                    for (int c = 0; c < NUM_CPUS; c++)
                    begin
                        load_reg[c] <= '0;
                    end
                    count_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign out_vm       = out_vm_reg;
    assign out_vcpu     = out_vcpu_reg;
    assign from_cpu     = from_cpu_reg;
    assign to_cpu       = to_cpu_reg;
    assign end_of_run   = kind_reg;

    `VLB_ASSERT(a_done_ends_run, (state_reg == S_DONE) |=> (result_valid && kind && !busy))
    `VLB_ASSERT_NEVER(a_move_same_cpu, result_valid && !kind && (from_cpu == to_cpu))
    `VLB_ASSERT_NEVER(a_count_overflow, count_reg > COUNT_W'(MAX_VCPUS))
    `VLB_ASSERT(a_move_while_busy, (result_valid && !kind) |-> busy)

endmodule

// ===== hw/rtl/vlb_ram.sv =====
module vlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import vlb_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [VM_W-1:0]   vm;
        logic [VCPU_W-1:0] vcpu;
        logic [CPU_W-1:0]  src;
        logic [CPU_W-1:0]  dst;
        logic              eor;
    } move_t;

    typedef struct packed {
        logic [VM_W-1:0]   vm;
        logic [VCPU_W-1:0] vcpu;
        logic [CPU_W-1:0]  cpu;
        logic [USE_W-1:0]  usage;
        logic              fin;
        logic              typed;
        move_t             exp;
    } row_t;

    localparam move_t DONE = '{kind: 1'b1, vm: '0, vcpu: '0, src: '0, dst: '0, eor: 1'b1};
    localparam move_t NONE = '0;
    localparam int CYCLE_LIMIT = 1000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [VM_W-1:0] vm_index = '0;
    logic [VCPU_W-1:0] vcpu_index = '0;
    logic [CPU_W-1:0] current_cpu = '0;
    logic [USE_W-1:0] usage_delta = '0;
    logic final_item = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic result_valid;
    logic kind;
    logic [VM_W-1:0] out_vm;
    logic [VCPU_W-1:0] out_vcpu;
    logic [CPU_W-1:0] from_cpu;
    logic [CPU_W-1:0] to_cpu;
    logic end_of_run;
    logic row_typed = 1'b0;
    move_t row_exp = '0;

    logic [LOAD_W-1:0] model_load [NUM_CPUS];
    rec_t model_recs [MAX_VCPUS];
    int model_count = 0;
    logic [3:0] act_reg = 4'd8;
    logic [7:0] margin_reg = 8'd64;
    logic [7:0] var_reg = 8'd102;
    move_t pending_moves [$];
    int errors = 0;
    int cycles = 0;

    vcpu_load_balancer i_dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int active_n();
        if (act_reg == 0)
            return 1;
        if (act_reg > NUM_CPUS)
            return NUM_CPUS;
        return int'(act_reg);
    endfunction

    task automatic balance_record(input rec_t r, input logic fin, output move_t moves [$]);
        int n;
        int best;
        logic [63:0] tot, scale, hi_lim, lo_lim, dst_lim;
        logic [LOAD_W-1:0] rest;
        rec_t q;
        n = active_n();
        moves = {};
        if (r.cpu < n && model_count < MAX_VCPUS)
        begin
            model_recs[model_count] = r;
            model_count++;
            model_load[r.cpu] += r.usage;
        end
        if (!fin)
            return;
        tot = 0;
        for (int c = 0; c < n; c++)
            tot += model_load[c];
        scale = 64'(n * 256);
        hi_lim = tot * (256 + margin_reg);
        lo_lim = tot * (256 - var_reg);
        dst_lim = tot * (256 + var_reg);
        for (int i = 0; i < model_count && tot != 0; i++)
        begin
            q = model_recs[i];
            if (q.cpu >= n)
                continue;
            if (64'(model_load[q.cpu]) * scale < hi_lim)
                continue;
            rest = model_load[q.cpu] >= q.usage ? model_load[q.cpu] - q.usage : '0;
            if (64'(rest) * scale < lo_lim)
                continue;
            best = 0;
            for (int c = 1; c < n; c++)
                if (model_load[c] < model_load[best])
                    best = c;
            if (best == q.cpu)
                continue;
            if ((64'(model_load[best]) + q.usage) * scale > dst_lim)
                continue;
            model_load[best] += q.usage;
            model_load[q.cpu] = rest;
            model_recs[i].cpu = CPU_W'(best);
            moves.push_back('{kind: 1'b0, vm: q.vm, vcpu: q.vcpu, src: q.cpu,
                              dst: CPU_W'(best), eor: 1'b0});
        end
        moves.push_back(DONE);
        foreach (model_load[c])
            model_load[c] = '0;
        model_count = 0;
    endtask

    always @(posedge clk)
    begin
        move_t got;
        move_t want;
        move_t moves [$];
        if (rst_n)
        begin
            cycles++;
            if (result_valid)
            begin
                got = '{kind, out_vm, out_vcpu, from_cpu, to_cpu, end_of_run};
                if (pending_moves.size() == 0)
                begin
                    $error("unexpected result %p", got);
                    errors++;
                end
                else
                begin
                    want = pending_moves.pop_front();
                    if (got.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, got.kind);
                        errors++;
                    end
                    if (got.vm !== want.vm)
                    begin
                        $error("out_vm: expected %0d, got %0d", want.vm, got.vm);
                        errors++;
                    end
                    if (got.vcpu !== want.vcpu)
                    begin
                        $error("out_vcpu: expected %0d, got %0d", want.vcpu, got.vcpu);
                        errors++;
                    end
                    if (got.src !== want.src)
                    begin
                        $error("from_cpu: expected %0d, got %0d", want.src, got.src);
                        errors++;
                    end
                    if (got.dst !== want.dst)
                    begin
                        $error("to_cpu: expected %0d, got %0d", want.dst, got.dst);
                        errors++;
                    end
                    if (got.eor !== want.eor)
                    begin
                        $error("end_of_run: expected %0d, got %0d", want.eor, got.eor);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                balance_record('{vm_index, vcpu_index, current_cpu, usage_delta},
                               final_item, moves);
                if (row_typed && final_item)
                    moves = {row_exp};
                foreach (moves[k])
                    pending_moves.push_back(moves[k]);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ACTIVE_CPUS: act_reg = cfg_data[3:0];
                    CFG_HIGH_MARGIN: margin_reg = cfg_data;
                    CFG_VARIANCE: var_reg = cfg_data;
                    default: ;
                endcase
            end
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_request(input row_t r);
        start <= 1'b1;
        vm_index <= r.vm;
        vcpu_index <= r.vcpu;
        current_cpu <= r.cpu;
        usage_delta <= r.usage;
        final_item <= r.fin;
        row_typed <= r.typed;
        row_exp <= r.exp;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pause_sender();
        if ($urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_moves.size() != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic row_t rand_row(input int n, input logic fin, input int hot);
        row_t r;
        r = '0;
        r.vm = VM_W'($urandom_range(0, 15));
        r.vcpu = VCPU_W'($urandom_range(0, 7));
        r.fin = fin;
        if ($urandom_range(0, 9) == 0)
            r.cpu = CPU_W'($urandom_range(0, 7));
        else if ($urandom_range(0, 1) == 0)
            r.cpu = CPU_W'(hot);
        else
            r.cpu = CPU_W'($urandom_range(0, n - 1));
        case ($urandom_range(0, 5))
            0: r.usage = USE_W'($urandom_range(0, 15));
            1: r.usage = USE_W'($urandom);
            2: r.usage = '1;
            default: r.usage = USE_W'($urandom_range(1000, 400000));
        endcase
        return r;
    endfunction

    row_t directed [16] = '{
        '{4'd0, 3'd0, 3'd0, 24'd0, 1'b1, 1'b1, DONE},
        '{4'd15, 3'd7, 3'd7, 24'hFFFFFF, 1'b0, 1'b1, NONE},
        '{4'd0, 3'd0, 3'd0, 24'hFFFFFF, 1'b0, 1'b1, NONE},
        '{4'd1, 3'd1, 3'd0, 24'd500000, 1'b0, 1'b0, NONE},
        '{4'd2, 3'd2, 3'd0, 24'd400000, 1'b0, 1'b0, NONE},
        '{4'd3, 3'd3, 3'd1, 24'd10, 1'b0, 1'b0, NONE},
        '{4'd4, 3'd4, 3'd2, 24'd900000, 1'b0, 1'b0, NONE},
        '{4'd5, 3'd5, 3'd3, 24'd0, 1'b1, 1'b0, NONE},
        '{4'd6, 3'd6, 3'd5, 24'd300000, 1'b0, 1'b0, NONE},
        '{4'd7, 3'd7, 3'd5, 24'd300000, 1'b0, 1'b0, NONE},
        '{4'd8, 3'd0, 3'd5, 24'd300000, 1'b0, 1'b0, NONE},
        '{4'd9, 3'd1, 3'd5, 24'd300000, 1'b1, 1'b0, NONE},
        '{4'd10, 3'd2, 3'd6, 24'd1, 1'b0, 1'b0, NONE},
        '{4'd11, 3'd3, 3'd6, 24'd1, 1'b0, 1'b0, NONE},
        '{4'd12, 3'd4, 3'd6, 24'd1, 1'b1, 1'b0, NONE},
        '{4'd13, 3'd5, 3'd4, 24'd0, 1'b1, 1'b1, DONE}
    };

    initial
    begin
        int n, len, hot, sent;
        logic [7:0] settings [6][3];
        settings = '{
            '{8'hF8, 8'd64, 8'd102},
            '{8'h00, 8'd0, 8'd0},
            '{8'h0F, 8'd255, 8'd255},
            '{8'h12, 8'd0, 8'd255},
            '{8'hA4, 8'd32, 8'd128},
            '{8'h55, 8'd128, 8'd200}
        };
        foreach (model_load[c])
            model_load[c] = '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[k])
        begin
            send_request(directed[k]);
            pause_sender();
        end
        drain();
        sent = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_ACTIVE_CPUS, settings[ph][0]);
            write_reg(CFG_HIGH_MARGIN, settings[ph][1]);
            write_reg(CFG_VARIANCE, settings[ph][2]);
            n = active_n();
            for (int run = 0; run < 10; run++)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40)
                                                   : $urandom_range(1, 10);
                hot = $urandom_range(0, n - 1);
                for (int k = 0; k < len; k++)
                begin
                    send_request(rand_row(n, k == len - 1, hot));
                    sent++;
                    pause_sender();
                end
            end
            drain();
        end
        while (sent < 480)
        begin
            n = active_n();
            hot = $urandom_range(0, n - 1);
            send_request(rand_row(n, $urandom_range(0, 5) == 0, hot));
            sent++;
            pause_sender();
        end
        send_request(rand_row(active_n(), 1'b1, 0));
        drain();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
